[design/sfr_pkg.sv]
// Package for the sensor frame receiver: widths, sync codes, sequencer states,
// shared-unit operations and the word request struct.
// No dependencies.
package sfr_pkg;

    localparam int FRAME_BYTES_MAX = 32;
    localparam int MEM_AW          = $clog2(FRAME_BYTES_MAX);
    localparam int CNT_W           = $clog2(FRAME_BYTES_MAX + 1);
    localparam int PL_W            = 5;
    localparam int IDX_W           = 4;
    localparam int WORD_W          = 16;

    localparam logic [7:0] SYNC_FIRST  = 8'h42;
    localparam logic [7:0] SYNC_SECOND = 8'h4d;
    localparam logic [PL_W-1:0] LENGTH_MIN   = 5'd4;
    localparam logic [PL_W-1:0] LENGTH_MAX   = 5'd28;
    localparam logic [PL_W-1:0] LENGTH_RESET = 5'd28;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRL_HI,
        ST_TRL_LO,
        ST_CHK,
        ST_ERR,
        ST_WHI,
        ST_WLO,
        ST_WOUT
    } t_state;

    typedef enum logic {
        OP_ADD,
        OP_CMP
    } t_alu_op;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] value;
        logic              status;
        logic              last;
    } t_word_req;

endpackage

[design/sfr_alu.sv]
// Shared 16-bit unit: wrapping add for the running checksum, equality
// compare for the trailer check.
// Depends on sfr_pkg.
module sfr_alu (
    input  sfr_pkg::t_alu_op            i_op,
    input  logic [sfr_pkg::WORD_W-1:0]  i_a,
    input  logic [sfr_pkg::WORD_W-1:0]  i_b,
    output logic [sfr_pkg::WORD_W-1:0]  o_sum,
    output logic                        o_eq
);

    always_comb begin
        o_sum = '0;
        o_eq  = 1'b0;
        unique case (i_op)
            sfr_pkg::OP_ADD: o_sum = i_a + i_b;
            sfr_pkg::OP_CMP: o_eq  = (i_a == i_b);
            default:         o_sum = '0;
        endcase
    end

endmodule

[design/sfr_ctrl.sv]
// Frame parser sequencer: header/length checks, frame byte store, trailer
// readback and compare, and payload word readout through the shared unit.
// Depends on sfr_pkg and sfr_alu.
module sfr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfr_pkg::PL_W-1:0]      i_cfg_data,
    input  logic                          i_rx_valid,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_rx_stall,
    output sfr_pkg::t_word_req            o_req,
    input  logic                          i_req_ack
);

    sfr_pkg::t_state r_state, n_state;

    logic [sfr_pkg::CNT_W-1:0]  r_count, n_count;
    logic [7:0]                 r_lenh, n_lenh;
    logic [sfr_pkg::WORD_W-1:0] r_sum, n_sum;
    logic [sfr_pkg::PL_W-1:0]   r_pl;
    logic [7:0]                 r_hi;
    logic [7:0]                 r_rd;
    logic [sfr_pkg::IDX_W-1:0]  r_idx, n_idx;

    logic [7:0] r_mem [sfr_pkg::FRAME_BYTES_MAX];

    logic                        accept;
    logic                        wr_en;
    logic                        fin;
    logic                        rd_en;
    logic [sfr_pkg::MEM_AW-1:0]  rd_addr;
    logic [sfr_pkg::CNT_W-1:0]   total;
    logic [sfr_pkg::CNT_W-1:0]   count_inc;
    logic [sfr_pkg::PL_W-1:0]    words;
    logic                        word_last;
    logic                        len_ok;

    sfr_pkg::t_alu_op            alu_op;
    logic [sfr_pkg::WORD_W-1:0]  alu_a, alu_b, alu_sum;
    logic                        alu_eq;

    sfr_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_eq  (alu_eq)
    );

    assign total     = {1'b0, r_pl} + sfr_pkg::CNT_W'(4);
    assign count_inc = r_count + sfr_pkg::CNT_W'(1);
    assign words     = (r_pl - sfr_pkg::PL_W'(2)) >> 1;
    assign word_last = ({1'b0, r_idx} + sfr_pkg::PL_W'(1)) == words;
    assign accept    = i_rx_valid && (r_state == sfr_pkg::ST_IDLE);
    assign o_rx_stall = (r_state != sfr_pkg::ST_IDLE);

    assign len_ok = (r_lenh == 8'd0) && (i_rx_byte == {3'b000, r_pl}) && !r_pl[0]
                 && (r_pl >= sfr_pkg::LENGTH_MIN) && (r_pl <= sfr_pkg::LENGTH_MAX);

    // byte intake: count, length and checksum updates
    always_comb begin
        n_count = r_count;
        n_lenh  = r_lenh;
        n_sum   = r_sum;
        wr_en   = 1'b0;
        fin     = 1'b0;
        if (accept) begin
            priority if (r_count == sfr_pkg::CNT_W'(0)) begin
                if (i_rx_byte == sfr_pkg::SYNC_FIRST) begin
                    wr_en   = 1'b1;
                    n_sum   = alu_sum;
                    n_count = count_inc;
                end
            end else if (r_count == sfr_pkg::CNT_W'(1)) begin
                if (i_rx_byte == sfr_pkg::SYNC_SECOND) begin
                    wr_en   = 1'b1;
                    n_sum   = alu_sum;
                    n_count = count_inc;
                end else begin
                    n_count = '0;
                    n_lenh  = '0;
                    n_sum   = '0;
                end
            end else if (r_count == sfr_pkg::CNT_W'(2)) begin
                wr_en   = 1'b1;
                n_lenh  = i_rx_byte;
                n_sum   = alu_sum;
                n_count = count_inc;
            end else if (r_count == sfr_pkg::CNT_W'(3)) begin
                if (len_ok) begin
                    wr_en   = 1'b1;
                    n_sum   = alu_sum;
                    n_count = count_inc;
                end else begin
                    n_count = '0;
                    n_lenh  = '0;
                    n_sum   = '0;
                end
            end else if (r_count >= sfr_pkg::CNT_W'(sfr_pkg::FRAME_BYTES_MAX)) begin
                n_count = '0;
                n_lenh  = '0;
                n_sum   = '0;
            end else begin
                wr_en = 1'b1;
                if ((r_count + sfr_pkg::CNT_W'(2)) < total)
                    n_sum = alu_sum;
                if (count_inc >= total) begin
                    // frame complete: parser restarts, sequencer checks trailer
                    fin     = 1'b1;
                    n_count = '0;
                    n_lenh  = '0;
                end else begin
                    n_count = count_inc;
                end
            end
        end
        // checksum is cleared once the trailer compare is done
        if (r_state == sfr_pkg::ST_CHK)
            n_sum = '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfr_pkg::ST_IDLE:   if (fin) n_state = sfr_pkg::ST_TRL_HI;
            sfr_pkg::ST_TRL_HI: n_state = sfr_pkg::ST_TRL_LO;
            sfr_pkg::ST_TRL_LO: n_state = sfr_pkg::ST_CHK;
            sfr_pkg::ST_CHK:    n_state = alu_eq ? sfr_pkg::ST_WHI : sfr_pkg::ST_ERR;
            sfr_pkg::ST_ERR:    if (i_req_ack) n_state = sfr_pkg::ST_IDLE;
            sfr_pkg::ST_WHI:    n_state = sfr_pkg::ST_WLO;
            sfr_pkg::ST_WLO:    n_state = sfr_pkg::ST_WOUT;
            sfr_pkg::ST_WOUT: begin
                if (i_req_ack)
                    n_state = word_last ? sfr_pkg::ST_IDLE : sfr_pkg::ST_WHI;
            end
            default:            n_state = sfr_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: memory reads, shared unit operands, word requests
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        alu_op  = sfr_pkg::OP_ADD;
        alu_a   = (r_count == sfr_pkg::CNT_W'(0)) ? '0 : r_sum;
        alu_b   = {8'd0, i_rx_byte};
        o_req   = '0;
        n_idx   = r_idx;
        unique case (r_state)
            sfr_pkg::ST_IDLE: ;
            sfr_pkg::ST_TRL_HI: begin
                rd_en   = 1'b1;
                rd_addr = sfr_pkg::MEM_AW'(total - sfr_pkg::CNT_W'(2));
            end
            sfr_pkg::ST_TRL_LO: begin
                rd_en   = 1'b1;
                rd_addr = sfr_pkg::MEM_AW'(total - sfr_pkg::CNT_W'(1));
            end
            sfr_pkg::ST_CHK: begin
                alu_op = sfr_pkg::OP_CMP;
                alu_a  = {r_hi, r_rd};
                alu_b  = r_sum;
                n_idx  = '0;
            end
            sfr_pkg::ST_ERR: begin
                o_req.valid  = 1'b1;
                o_req.status = 1'b1;
                o_req.last   = 1'b1;
            end
            sfr_pkg::ST_WHI: begin
                rd_en   = 1'b1;
                rd_addr = {r_idx, 1'b0} + sfr_pkg::MEM_AW'(4);
            end
            sfr_pkg::ST_WLO: begin
                rd_en   = 1'b1;
                rd_addr = {r_idx, 1'b0} + sfr_pkg::MEM_AW'(5);
            end
            sfr_pkg::ST_WOUT: begin
                o_req.valid = 1'b1;
                o_req.idx   = r_idx;
                o_req.value = {r_hi, r_rd};
                o_req.last  = word_last;
                if (i_req_ack)
                    n_idx = r_idx + sfr_pkg::IDX_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::ST_IDLE;
            r_count <= '0;
            r_lenh  <= '0;
            r_sum   <= '0;
            r_pl    <= sfr_pkg::LENGTH_RESET;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_lenh  <= n_lenh;
            r_sum   <= n_sum;
            r_idx   <= n_idx;
            if (i_cfg_we)
                r_pl <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_mem[r_count[sfr_pkg::MEM_AW-1:0]] <= i_rx_byte;
        if (rd_en)
            r_rd <= r_mem[rd_addr];
        // high byte copied from the read register while the low byte is read
        if (r_state == sfr_pkg::ST_TRL_LO || r_state == sfr_pkg::ST_WLO)
            r_hi <= r_rd;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sfr_pkg::CNT_W'(sfr_pkg::FRAME_BYTES_MAX))
        else $error("byte count beyond frame store");

    a_hunt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_count == sfr_pkg::CNT_W'(0) && i_rx_byte != sfr_pkg::SYNC_FIRST)
        |=> (r_count == sfr_pkg::CNT_W'(0)))
        else $error("left hunt without sync byte");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req.valid && i_req_ack && o_req.last) |=> (r_state == sfr_pkg::ST_IDLE))
        else $error("sequencer busy after final result");

    a_chk_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfr_pkg::ST_CHK)
        |=> (r_state == sfr_pkg::ST_ERR || r_state == sfr_pkg::ST_WHI))
        else $error("trailer check did not branch");

endmodule

[design/sensor_frame_receiver.sv]
// Top level of the sensor frame receiver: parser sequencer plus the result
// output register.
// Depends on sfr_pkg and sfr_ctrl.
//
//  channel   direction  handshake                 payload
//  rx        in         i_rx_valid / o_rx_stall   i_rx_byte
//  result    out        o_res_valid / i_res_stall o_word_index, o_word_value,
//                                                 o_frame_status, o_last
//  config    in         i_cfg_we                  i_cfg_data (payload_length)
//
// A byte that does not end a frame leaves the sequencer idle, so no stall follows.
// The final byte of a frame starts a trailer readback (TRL_HI, TRL_LO, CHK),
// then each payload word takes two reads of the single frame-store read port
// plus the hand-off to the output register: up to 13 words for a frame.
// Reset is synchronous, active low; payload_length returns to 28.
// A stalled result holds the output register and the sequencer waits on it.
module sensor_frame_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfr_pkg::PL_W-1:0]      i_cfg_data,
    input  logic                          i_rx_valid,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_rx_stall,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic [sfr_pkg::IDX_W-1:0]     o_word_index,
    output logic [sfr_pkg::WORD_W-1:0]    o_word_value,
    output logic                          o_frame_status,
    output logic                          o_last
);

    sfr_pkg::t_word_req req;
    logic               out_free;

    logic                       r_valid;
    logic [sfr_pkg::IDX_W-1:0]  r_index;
    logic [sfr_pkg::WORD_W-1:0] r_value;
    logic                       r_status;
    logic                       r_last;

    assign out_free = !r_valid || !i_res_stall;

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_stall (o_rx_stall),
        .o_req      (req),
        .i_req_ack  (out_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && req.valid) begin
            r_index  <= req.idx;
            r_value  <= req.value;
            r_status <= req.status;
            r_last   <= req.last;
        end
    end

    assign o_res_valid    = r_valid;
    assign o_word_index   = r_index;
    assign o_word_value   = r_value;
    assign o_frame_status = r_status;
    assign o_last         = r_last;

endmodule

[tb/sfr_word_checker.sv]
// Checker for the sensor frame receiver: follows the rx and result channels,
// parses each accepted byte on its own and compares every result it sees.
// Depends on sfr_pkg.
module sfr_word_checker
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PL_W-1:0]   i_cfg_data,
    input  logic              i_rx_valid,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_rx_stall,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic [IDX_W-1:0]  i_word_index,
    input  logic [WORD_W-1:0] i_word_value,
    input  logic              i_frame_status,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending,
    output logic              o_hunting
);

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] value;
        logic              status;
        logic              last;
    } frame_word_t;

    frame_word_t expected_words[$];

    logic [PL_W-1:0] payload_len;
    logic [5:0]      held_bytes;
    logic [7:0]      len_hi;
    logic [15:0]     frame_sum;
    logic [7:0]      frame_store[FRAME_BYTES_MAX];

    function automatic void restart_hunt();
        held_bytes = '0;
        len_hi     = '0;
        frame_sum  = '0;
    endfunction

    function automatic bit length_accepted(input logic [15:0] len);
        return len == 16'(payload_len) && !len[0] && len >= 16'(LENGTH_MIN)
            && len <= 16'(LENGTH_MAX) && int'(len) + 4 <= FRAME_BYTES_MAX;
    endfunction

    // Advance the parser by one byte; queue whatever words the byte releases.
    function automatic void parse_byte(input logic [7:0] b);
        int          total;
        int          n_words;
        logic [15:0] trailer;
        frame_word_t w;
        total = int'(payload_len) + 4;
        case (held_bytes)
            6'd0: begin
                if (b != SYNC_FIRST) return;
                frame_sum = '0;
            end
            6'd1: begin
                if (b != SYNC_SECOND) begin
                    restart_hunt();
                    return;
                end
            end
            6'd2: begin
                len_hi = b;
            end
            6'd3: begin
                if (!length_accepted({len_hi, b})) begin
                    restart_hunt();
                    return;
                end
            end
            default: ;
        endcase
        if (held_bytes >= FRAME_BYTES_MAX) begin
            restart_hunt();
            return;
        end
        frame_store[held_bytes] = b;
        if (held_bytes < 4 || int'(held_bytes) + 2 < total)
            frame_sum = frame_sum + 16'(b);
        held_bytes = held_bytes + 6'd1;
        if (held_bytes < 4 || int'(held_bytes) < total) return;

        trailer = {frame_store[total-2], frame_store[total-1]};
        if (trailer != frame_sum) begin
            w.idx    = '0;
            w.value  = '0;
            w.status = STATUS_BAD;
            w.last   = 1'b1;
            expected_words.push_back(w);
        end else begin
            n_words = (int'(payload_len) - 2) / 2;
            for (int i = 0; i < n_words; i++) begin
                w.idx    = IDX_W'(i);
                w.value  = {frame_store[4+2*i], frame_store[5+2*i]};
                w.status = STATUS_GOOD;
                w.last   = (i + 1 == n_words);
                expected_words.push_back(w);
            end
        end
        restart_hunt();
    endfunction

    function automatic int field_differs(input string name, input logic [15:0] exp_v,
                                         input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        frame_word_t exp_w;
        if (!i_rst_n) begin
            payload_len = LENGTH_RESET;
            restart_hunt();
            expected_words.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result with nothing expected: index %0d value %0h status %0b last %0b",
                           i_word_index, i_word_value, i_frame_status, i_last);
                    o_fail_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    o_fail_count += field_differs("word_index", 16'(exp_w.idx),
                                                  16'(i_word_index));
                    o_fail_count += field_differs("word_value", exp_w.value, i_word_value);
                    o_fail_count += field_differs("frame_status", 16'(exp_w.status),
                                                  16'(i_frame_status));
                    o_fail_count += field_differs("last", 16'(exp_w.last), 16'(i_last));
                end
            end
            // a byte taken at this edge still sees the old length
            if (i_rx_valid && !i_rx_stall)
                parse_byte(i_rx_byte);
            if (i_cfg_we)
                payload_len = i_cfg_data;
        end
        o_pending = expected_words.size();
        o_hunting = (held_bytes == 0);
    end

endmodule

[tb/tb_sensor_frame_receiver.sv]
// Testbench top for the sensor frame receiver: clock, reset, byte and
// register stimulus, result-side stalls and the verdict.
// Depends on sfr_pkg, sensor_frame_receiver and sfr_word_checker.
module tb_sensor_frame_receiver;
    import sfr_pkg::*;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    localparam int N_PHASES = 9;
    localparam logic [PL_W-1:0] PHASE_LEN [N_PHASES] =
        '{5'd4, 5'd28, 5'd31, 5'd16, 5'd7, 5'd0, 5'd2, 5'd14, 5'd28};
    localparam int PHASE_BUDGET [N_PHASES] = '{40, 90, 25, 40, 20, 20, 15, 40, 55};
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 50;
    localparam int DRAIN_LIMIT    = 5000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [PL_W-1:0]   cfg_data;
    logic              rx_valid;
    logic [7:0]        rx_byte;
    logic              rx_stall;
    logic              res_valid;
    logic              res_stall;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_value;
    logic              frame_status;
    logic              last;

    int   fail_count;
    int   pending;
    logic hunting;
    int   bytes_sent;
    logic hold_go;
    logic burst_on;

    sensor_frame_receiver u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .i_rx_byte      (rx_byte),
        .o_rx_stall     (rx_stall),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_word_index   (word_index),
        .o_word_value   (word_value),
        .o_frame_status (frame_status),
        .o_last         (last)
    );

    sfr_word_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .i_rx_byte      (rx_byte),
        .i_rx_stall     (rx_stall),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_word_index   (word_index),
        .i_word_value   (word_value),
        .i_frame_status (frame_status),
        .i_last         (last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_hunting      (hunting)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #3000000;
        $display("sensor_frame_receiver: mismatch");
        $finish;
    end

    // Result side: random stalls, one long hold-off, none during the burst phase.
    initial begin : result_stalls
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                res_stall <= 1'b1;
                hold_left--;
            end else if (burst_on) begin
                res_stall <= 1'b0;
            end else begin
                res_stall <= ($urandom_range(99) < 27);
            end
        end
    end

    // One byte request; returns at the falling edge after it is taken.
    task automatic send_byte(input logic [7:0] b);
        if (!burst_on) begin
            while ($urandom_range(99) < 27) begin
                rx_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge i_clk);
        while (rx_stall) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Header, body and trailer; only the first keep bytes go out.
    task automatic send_frame(input logic [15:0] len_field, input int body_len,
                              input fill_t fill, input bit corrupt, input int keep);
        logic [7:0]  fb[$];
        logic [7:0]  b;
        logic [15:0] sum;
        logic [15:0] trl;
        fb  = {SYNC_FIRST, SYNC_SECOND, len_field[15:8], len_field[7:0]};
        for (int i = 0; i < body_len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hff;
                default: begin
                    b = 8'($urandom);
                    // sync bytes inside the body must not restart the parser
                    if ($urandom_range(7) == 0)
                        b = $urandom_range(1) ? SYNC_FIRST : SYNC_SECOND;
                end
            endcase
            fb.push_back(b);
        end
        sum = '0;
        foreach (fb[i]) sum = sum + 16'(fb[i]);
        trl = corrupt ? (sum ^ 16'($urandom_range(1, 65535))) : sum;
        fb.push_back(trl[15:8]);
        fb.push_back(trl[7:0]);
        foreach (fb[i])
            if (i < keep) send_byte(fb[i]);
    endtask

    function automatic fill_t random_fill();
        int r;
        r = $urandom_range(9);
        if (r == 0) return FILL_ZERO;
        if (r == 1) return FILL_ONES;
        return FILL_RANDOM;
    endfunction

    task automatic send_random_sequence(input logic [PL_W-1:0] plen);
        int          pick;
        int          body;
        logic [15:0] bad_len;
        logic [7:0]  second;
        pick = $urandom_range(99);
        body = (plen >= 2) ? int'(plen) - 2 : 0;
        if (pick < 60) begin
            send_frame({11'd0, plen}, body, random_fill(), 1'b0, 64);
        end else if (pick < 70) begin
            send_frame({11'd0, plen}, body, random_fill(), 1'b1, 64);
        end else if (pick < 75) begin
            second = 8'($urandom);
            if (second == SYNC_SECOND) second = SYNC_FIRST;
            send_byte(SYNC_FIRST);
            send_byte(second);
        end else if (pick < 80) begin
            if ($urandom_range(1))
                bad_len = {8'($urandom_range(1, 255)), 3'b000, plen};
            else
                bad_len = {11'd0, plen ^ PL_W'($urandom_range(1, 31))};
            send_frame(bad_len, body, FILL_RANDOM, 1'b0, $urandom_range(4, 8));
        end else if (pick < 87) begin
            // cut short: whatever follows is taken as the rest of the frame
            send_frame({11'd0, plen}, body, FILL_RANDOM, 1'b0, $urandom_range(4, body + 3));
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
    endtask

    // Zeros never open a frame, so they walk the parser back to hunting.
    task automatic flush_to_hunt();
        while (!hunting) send_byte(8'h00);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        rx_valid <= 1'b0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_length(input logic [PL_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        int start;
        i_rst_n    = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        rx_valid   = 1'b0;
        rx_byte    = '0;
        bytes_sent = 0;
        hold_go    = 1'b0;
        burst_on   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset length 28: noise, bad second byte (not re-tested), stray 0x4d,
        // length mismatch
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h00);
        send_byte(8'd27);
        drain();
        set_length(LENGTH_MIN);
        send_frame({11'd0, LENGTH_MIN}, 2, FILL_ONES, 1'b0, 64);
        send_frame({11'd0, LENGTH_MIN}, 2, FILL_ZERO, 1'b1, 64);

        for (int p = 0; p < N_PHASES; p++) begin
            flush_to_hunt();
            drain();
            set_length(PHASE_LEN[p]);
            burst_on <= (p == N_PHASES - 1);
            if (p == 1) hold_go <= 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BUDGET[p])
                send_random_sequence(PHASE_LEN[p]);
        end

        drain();
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("sensor_frame_receiver: match");
        else
            $display("sensor_frame_receiver: mismatch");
        $finish;
    end

endmodule

[filelist.f]
design/sfr_pkg.sv
design/sfr_alu.sv
design/sfr_ctrl.sv
design/sensor_frame_receiver.sv
tb/sfr_word_checker.sv
tb/tb_sensor_frame_receiver.sv
